[hdl/assert_macros.svh]
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is asserted (active low).
`define SKPI_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// Clocked assertion that also holds during reset.
`define SKPI_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) else $error("assertion failed");

`endif

[hdl/skpi_pkg.sv]
// Shared types and constants for the sorted key position index.
package skpi_pkg;

    localparam int unsigned MAX_KEYS_DEF      = 256;
    localparam int unsigned MAX_POSITIONS_DEF = 8;
    localparam int unsigned KEY_W             = 31;
    localparam int unsigned STATUS_W          = 3;
    localparam int unsigned IN_TDATA_W        = 72;

    typedef enum logic [1:0] {
        OP_PUT  = 2'd0,
        OP_GET  = 2'd1,
        OP_RANK = 2'd2,
        OP_BAD  = 2'd3
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK          = 3'd0,
        ST_NOT_FOUND   = 3'd1,
        ST_BAD_OPERAND = 3'd2,
        ST_TABLE_FULL  = 3'd3,
        ST_LIST_FULL   = 3'd4
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SRCH,
        S_SCMP,
        S_LRD,
        S_LWT,
        S_SHF,
        S_SDR,
        S_INS,
        S_PRD,
        S_PEM,
        S_RESP
    } t_state;

endpackage

[hdl/skpi_ram.sv]
// Simple dual-port synchronous RAM, one write and one registered read port.
module skpi_ram #(
    parameter int unsigned DEPTH = 256,
    parameter int unsigned AW    = 8,
    parameter int unsigned DW    = 32
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[hdl/sorted_key_position_index_top.sv]
// Top level: sorted key table with per-key position lists, sequenced over two RAMs.
//
//  channel  | dir | handshake             | payload
//  ---------+-----+-----------------------+-------------------------------------------
//  request  | in  | i_s_tvalid/o_s_tready | tuser opcode; tdata key, position, rank
//  result   | out | o_m_tvalid/i_m_tready | tdata status..count; tlast end of run
//
// One request at a time. Search: each halving step runs S_SRCH then S_SCMP.
// A put of a new key shifts the tail of the position RAM one entry per cycle
// in S_SHF, with the key entries, then drains in S_SDR and inserts in S_INS; the
// single write port of that RAM sets this rate. A get reads each returned position in S_PRD and sends it from S_PEM.
// Reset (synchronous, active low) clears the key count and control only; the
// RAMs need no clearing, entries at or above the key count are never used.
// The result register lets the sequencer go idle while a result still waits.
module sorted_key_position_index_top
    import skpi_pkg::*;
#(
    parameter int unsigned MAX_KEYS      = MAX_KEYS_DEF,
    parameter int unsigned MAX_POSITIONS = MAX_POSITIONS_DEF,
    localparam int unsigned CW      = $clog2(MAX_KEYS + 1),
    localparam int unsigned PCW     = $clog2(MAX_POSITIONS + 1),
    localparam int unsigned OUT_RAW = STATUS_W + CW + KEY_W + KEY_W + PCW,
    localparam int unsigned OUT_W   = ((OUT_RAW + 7) / 8) * 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // request
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    // tdata: lookup_key[31:0], record_position[63:32], rank[71:64]
    input  logic [IN_TDATA_W-1:0] i_s_tdata,
    // tuser: opcode[1:0]
    input  logic [1:0]            i_s_tuser,
    // result
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    // tdata: status, unique_keys, found_key, position_out, position_count, zero pad
    output logic [OUT_W-1:0]      o_m_tdata,
    output logic                  o_m_tlast
);

    localparam int unsigned KW  = $clog2(MAX_KEYS);
    localparam int unsigned PW  = $clog2(MAX_KEYS * MAX_POSITIONS);
    localparam int unsigned KMW = PCW + KEY_W;

    // sequencer state
    t_state r_state, n_state;
    t_op    r_op, n_op;
    logic [KEY_W-1:0] r_key, n_key;
    logic [KEY_W-1:0] r_pos, n_pos;
    logic [CW-1:0]    r_count, n_count;
    logic [CW-1:0]    r_lo, n_lo, r_hi, n_hi;
    logic [KW-1:0]    r_mid, n_mid;
    logic [CW-1:0]    r_slot, n_slot;
    logic             r_in, n_in;
    logic [KEY_W-1:0] r_fk, n_fk;
    logic [PCW-1:0]   r_len, n_len;
    logic [PCW-1:0]   r_i, n_i;
    logic [PW-1:0]    r_pa, n_pa;
    logic [KW-1:0]    r_ki, n_ki;
    logic             r_shv, n_shv;
    logic [PW-1:0]    r_wpa, n_wpa;
    logic [KW-1:0]    r_wki, n_wki;
    // staged single result
    t_status          r_rst, n_rst;
    logic [KEY_W-1:0] r_rfk, n_rfk;
    logic [KEY_W-1:0] r_rpo, n_rpo;
    logic [PCW-1:0]   r_rpc, n_rpc;
    // result register
    logic             r_mv, n_mv;
    t_status          r_ost, n_ost;
    logic [CW-1:0]    r_ouk, n_ouk;
    logic [KEY_W-1:0] r_ofk, n_ofk;
    logic [KEY_W-1:0] r_opo, n_opo;
    logic [PCW-1:0]   r_opc, n_opc;
    logic             r_olast, n_olast;

    // RAM ports
    logic           k_we, k_re, p_we, p_re;
    logic [KW-1:0]  k_waddr, k_raddr;
    logic [KMW-1:0] k_wdata, k_rdata;
    logic [PW-1:0]  p_waddr, p_raddr;
    logic [KEY_W-1:0] p_wdata, p_rdata;

    // decode helpers
    logic             w_accept, w_out_free;
    logic [CW-1:0]    w_mid;
    logic [KEY_W-1:0] w_rkey;
    logic [PCW-1:0]   w_rlen;
    logic             w_found, w_list_full, w_tab_full, w_last;
    logic [PW-1:0]    w_base;
    logic             w_kneg, w_pneg, w_rank_bad;

    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_out_free = !r_mv || i_m_tready;
    assign w_mid      = r_lo + ((r_hi - r_lo) >> 1);
    assign w_rkey     = k_rdata[KEY_W-1:0];
    assign w_rlen     = k_rdata[KMW-1:KEY_W];
    assign w_found    = r_in && ((r_op == OP_RANK) || (w_rkey == r_key));
    assign w_list_full = (32'(w_rlen) >= 32'(MAX_POSITIONS));
    assign w_tab_full  = (32'(r_count) >= 32'(MAX_KEYS));
    assign w_base     = PW'(r_slot[KW-1:0]) * PW'(MAX_POSITIONS);
    assign w_last     = ((r_i + PCW'(1)) == r_len);
    assign w_kneg     = i_s_tdata[31];
    assign w_pneg     = i_s_tdata[63];
    assign w_rank_bad = (32'(i_s_tdata[71:64]) >= 32'(r_count));

    skpi_ram #(.DEPTH(MAX_KEYS), .AW(KW), .DW(KMW)) u_kmem (
        .i_clk  (i_clk),
        .i_we   (k_we),
        .i_waddr(k_waddr),
        .i_wdata(k_wdata),
        .i_re   (k_re),
        .i_raddr(k_raddr),
        .o_rdata(k_rdata)
    );

    skpi_ram #(.DEPTH(MAX_KEYS * MAX_POSITIONS), .AW(PW), .DW(KEY_W)) u_pmem (
        .i_clk  (i_clk),
        .i_we   (p_we),
        .i_waddr(p_waddr),
        .i_wdata(p_wdata),
        .i_re   (p_re),
        .i_raddr(p_raddr),
        .o_rdata(p_rdata)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    case (t_op'(i_s_tuser))
                        OP_PUT:  n_state = (w_kneg || w_pneg) ? S_RESP : S_SRCH;
                        OP_GET:  n_state = w_kneg ? S_RESP : S_SRCH;
                        OP_RANK: n_state = w_rank_bad ? S_RESP : S_LRD;
                        default: n_state = S_RESP;
                    endcase
                end
            end
            S_SRCH: n_state = (r_lo < r_hi) ? S_SCMP : S_LRD;
            S_SCMP: n_state = S_SRCH;
            S_LRD:  n_state = S_LWT;
            S_LWT: begin
                if (r_op == OP_PUT) begin
                    if (w_found || w_tab_full) begin
                        n_state = S_RESP;
                    end else begin
                        n_state = r_in ? S_SHF : S_INS;
                    end
                end else if (w_found && (w_rlen != '0)) begin
                    n_state = S_PRD;
                end else begin
                    n_state = S_RESP;
                end
            end
            S_SHF:  n_state = (r_pa == w_base) ? S_SDR : S_SHF;
            S_SDR:  n_state = S_INS;
            S_INS:  n_state = S_RESP;
            S_PRD:  n_state = S_PEM;
            S_PEM: begin
                if (w_out_free) begin
                    n_state = w_last ? S_IDLE : S_PRD;
                end
            end
            S_RESP: n_state = w_out_free ? S_IDLE : S_RESP;
            default: n_state = S_IDLE;
        endcase
    end

    // datapath and RAM control
    always_comb begin
        n_op = r_op;  n_key = r_key;  n_pos = r_pos;  n_count = r_count;
        n_lo = r_lo;  n_hi = r_hi;    n_mid = r_mid;  n_slot = r_slot;
        n_in = r_in;  n_fk = r_fk;    n_len = r_len;  n_i = r_i;
        n_pa = r_pa;  n_ki = r_ki;    n_shv = r_shv;  n_wpa = r_wpa;
        n_wki = r_wki;
        n_rst = r_rst; n_rfk = r_rfk; n_rpo = r_rpo; n_rpc = r_rpc;
        n_mv = r_mv && !i_m_tready;
        n_ost = r_ost; n_ouk = r_ouk; n_ofk = r_ofk; n_opo = r_opo;
        n_opc = r_opc; n_olast = r_olast;
        k_we = 1'b0; k_waddr = r_slot[KW-1:0]; k_wdata = {w_rlen, w_rkey};
        k_re = 1'b0; k_raddr = r_slot[KW-1:0];
        p_we = 1'b0; p_waddr = w_base; p_wdata = r_pos;
        p_re = 1'b0; p_raddr = r_pa;
        o_s_tready = (r_state == S_IDLE);

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_op  = t_op'(i_s_tuser);
                    n_key = i_s_tdata[30:0];
                    n_pos = i_s_tdata[62:32];
                    n_lo  = '0;
                    n_hi  = r_count;
                    n_slot = CW'(i_s_tdata[71:64]);
                    n_in  = 1'b1;
                    n_rfk = '0; n_rpo = '0; n_rpc = '0;
                    n_rst = (t_op'(i_s_tuser) == OP_RANK) ? ST_NOT_FOUND : ST_BAD_OPERAND;
                end
            end
            S_SRCH: begin
                if (r_lo < r_hi) begin
                    k_re    = 1'b1;
                    k_raddr = w_mid[KW-1:0];
                    n_mid   = w_mid[KW-1:0];
                end else begin
                    n_slot = r_lo;
                    n_in   = (r_lo < r_count);
                end
            end
            S_SCMP: begin
                if (w_rkey < r_key) begin
                    n_lo = CW'(r_mid) + CW'(1);
                end else begin
                    n_hi = CW'(r_mid);
                end
            end
            S_LRD: begin
                k_re = 1'b1;
            end
            S_LWT: begin
                if (r_op == OP_PUT) begin
                    if (w_found) begin
                        if (w_list_full) begin
                            n_rst = ST_LIST_FULL; n_rfk = r_key; n_rpc = w_rlen;
                        end else begin
                            p_we    = 1'b1;
                            p_waddr = w_base + PW'(w_rlen);
                            k_we    = 1'b1;
                            k_wdata = {w_rlen + PCW'(1), w_rkey};
                            n_rst = ST_OK; n_rfk = r_key; n_rpo = r_pos;
                            n_rpc = w_rlen + PCW'(1);
                        end
                    end else if (w_tab_full) begin
                        n_rst = ST_TABLE_FULL;
                    end else begin
                        n_ki  = KW'(r_count - CW'(1));
                        n_pa  = PW'(r_count) * PW'(MAX_POSITIONS) - PW'(1);
                        n_shv = 1'b0;
                    end
                end else if (w_found) begin
                    n_fk  = w_rkey;
                    n_len = (32'(w_rlen) > 32'(MAX_POSITIONS)) ? PCW'(MAX_POSITIONS) : w_rlen;
                    n_pa  = w_base;
                    n_i   = '0;
                    n_rst = ST_OK; n_rfk = w_rkey;   // empty list: single item
                end else begin
                    n_rst = ST_NOT_FOUND;
                end
            end
            S_SHF: begin
                // read entry i, write it one slot up on the next cycle
                k_re    = 1'b1;
                k_raddr = r_ki;
                p_re    = 1'b1;
                p_raddr = r_pa;
                k_we    = r_shv;
                k_waddr = r_wki;
                k_wdata = k_rdata;
                p_we    = r_shv;
                p_waddr = r_wpa;
                p_wdata = p_rdata;
                n_shv   = 1'b1;
                n_wki   = r_ki + KW'(1);
                n_wpa   = r_pa + PW'(MAX_POSITIONS);
                n_pa    = r_pa - PW'(1);
                // step to the key below once the first position of this slot is read
                if (w_base != r_pa && r_pa == PW'(r_ki) * PW'(MAX_POSITIONS)) begin
                    n_ki = r_ki - KW'(1);
                end
            end
            S_SDR: begin
                k_we    = r_shv;
                k_waddr = r_wki;
                k_wdata = k_rdata;
                p_we    = r_shv;
                p_waddr = r_wpa;
                p_wdata = p_rdata;
                n_shv   = 1'b0;
            end
            S_INS: begin
                k_we    = 1'b1;
                k_wdata = {PCW'(1), r_key};
                p_we    = 1'b1;
                n_count = r_count + CW'(1);
                n_rst = ST_OK; n_rfk = r_key; n_rpo = r_pos; n_rpc = PCW'(1);
            end
            S_PRD: begin
                p_re = 1'b1;
            end
            S_PEM: begin
                if (w_out_free) begin
                    n_mv = 1'b1; n_ost = ST_OK; n_ouk = r_count; n_ofk = r_fk;
                    n_opo = p_rdata; n_opc = r_len; n_olast = w_last;
                    n_i  = r_i + PCW'(1);
                    n_pa = r_pa + PW'(1);
                end
            end
            S_RESP: begin
                if (w_out_free) begin
                    n_mv = 1'b1; n_ost = r_rst; n_ouk = r_count; n_ofk = r_rfk;
                    n_opo = r_rpo; n_opc = r_rpc; n_olast = 1'b1;
                end
            end
            default: begin
                n_mv = r_mv && !i_m_tready;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_mv    <= 1'b0;
            r_shv   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_mv    <= n_mv;
            r_shv   <= n_shv;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op <= n_op;   r_key <= n_key; r_pos <= n_pos;
        r_lo <= n_lo;   r_hi <= n_hi;   r_mid <= n_mid; r_slot <= n_slot;
        r_in <= n_in;   r_fk <= n_fk;   r_len <= n_len; r_i <= n_i;
        r_pa <= n_pa;   r_ki <= n_ki;   r_wpa <= n_wpa; r_wki <= n_wki;
        r_rst <= n_rst; r_rfk <= n_rfk; r_rpo <= n_rpo; r_rpc <= n_rpc;
        r_ost <= n_ost; r_ouk <= n_ouk; r_ofk <= n_ofk; r_opo <= n_opo;
        r_opc <= n_opc; r_olast <= n_olast;
    end

    assign o_m_tvalid = r_mv;
    assign o_m_tlast  = r_olast;
    assign o_m_tdata  = OUT_W'({r_opc, r_opo, r_ofk, r_ouk, r_ost});

    `include "assert_macros.svh"

    `SKPI_ASSERT(a_count_range, i_clk, i_rst_n, 32'(r_count) <= 32'(MAX_KEYS))
    `SKPI_ASSERT(a_ins_step, i_clk, i_rst_n, (r_state == S_INS) |=> (r_count == $past(r_count) + CW'(1)))
    `SKPI_ASSERT(a_shift_order, i_clk, i_rst_n, (r_state == S_SHF && r_shv) |-> (r_wpa > r_pa))
    `SKPI_ASSERT(a_ready_idle, i_clk, i_rst_n, o_s_tready == (r_state == S_IDLE))

endmodule

[sim/tb.sv]
// Testbench for the sorted key position index: directed table and random phases.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import skpi_pkg::*;

    localparam int unsigned N_KEYS = MAX_KEYS_DEF;
    localparam int unsigned N_POS  = MAX_POSITIONS_DEF;
    localparam int unsigned LIMIT  = 2000000;
    // longest shift of a put: whole position RAM plus search
    localparam int unsigned SETTLE = N_KEYS * N_POS + 64;

    typedef struct {
        t_op         op;
        logic [31:0] key;
        logic [31:0] pos;
        logic [7:0]  rank;
    } t_req;

    typedef struct {
        t_status     status;
        logic [8:0]  uniq;
        logic [30:0] fkey;
        logic [30:0] fpos;
        logic [3:0]  cnt;
        logic        last;
    } t_res;

    // directed row: request plus an optional typed-in single result
    typedef struct {
        t_req req;
        bit   typed;
        t_res res;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [71:0] i_s_tdata = '0;
    logic [1:0]  i_s_tuser = '0;
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [79:0] o_m_tdata;
    logic        o_m_tlast;

    sorted_key_position_index_top dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(i_s_tvalid), .o_s_tready(o_s_tready),
        .i_s_tdata(i_s_tdata), .i_s_tuser(i_s_tuser),
        .o_m_tvalid(o_m_tvalid), .i_m_tready(i_m_tready),
        .o_m_tdata(o_m_tdata), .o_m_tlast(o_m_tlast)
    );

    // shadow of the table
    logic [30:0] sh_keys [N_KEYS];
    int          sh_lens [N_KEYS];
    logic [30:0] sh_pos  [N_KEYS][N_POS];
    int          sh_count;

    t_res pending_results[$];
    int   errors = 0;
    int   cycles = 0;
    int   send_idle_pct = 0;
    int   recv_stall_pct = 0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        i_m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    function automatic t_res mk(t_status st, int uq, logic [30:0] fk, logic [30:0] po,
                                int pc, bit lst);
        t_res r;
        r.status = st; r.uniq = uq[8:0]; r.fkey = fk; r.fpos = po;
        r.cnt = pc[3:0]; r.last = lst;
        return r;
    endfunction

    function automatic int find_slot(logic [30:0] k);
        int lo, hi, mid;
        lo = 0; hi = sh_count;
        while (lo < hi) begin
            mid = lo + (hi - lo) / 2;
            if (sh_keys[mid] < k) lo = mid + 1;
            else hi = mid;
        end
        return lo;
    endfunction

    task automatic queue_entry(int slot);
        int n;
        n = sh_lens[slot];
        for (int i = 0; i < n; i++)
            pending_results.push_back(mk(ST_OK, sh_count, sh_keys[slot], sh_pos[slot][i],
                                         n, i == n - 1));
    endtask

    // update the shadow table and queue the results one request causes
    task automatic predict_lookup(t_req rq);
        logic [30:0] k, p;
        int slot, n;
        k = rq.key[30:0];
        p = rq.pos[30:0];
        case (rq.op)
            OP_PUT: begin
                if (rq.key[31] || rq.pos[31]) begin
                    pending_results.push_back(mk(ST_BAD_OPERAND, sh_count, 0, 0, 0, 1));
                end else begin
                    slot = find_slot(k);
                    if (slot < sh_count && sh_keys[slot] == k) begin
                        n = sh_lens[slot];
                        if (n >= N_POS) begin
                            pending_results.push_back(mk(ST_LIST_FULL, sh_count, k, 0, n, 1));
                        end else begin
                            sh_pos[slot][n] = p;
                            sh_lens[slot] = n + 1;
                            pending_results.push_back(mk(ST_OK, sh_count, k, p, n + 1, 1));
                        end
                    end else if (sh_count >= N_KEYS) begin
                        pending_results.push_back(mk(ST_TABLE_FULL, sh_count, 0, 0, 0, 1));
                    end else begin
                        for (int i = sh_count; i > slot; i--) begin
                            sh_keys[i] = sh_keys[i-1];
                            sh_lens[i] = sh_lens[i-1];
                            sh_pos[i] = sh_pos[i-1];
                        end
                        sh_keys[slot] = k;
                        sh_lens[slot] = 1;
                        sh_pos[slot][0] = p;
                        sh_count++;
                        pending_results.push_back(mk(ST_OK, sh_count, k, p, 1, 1));
                    end
                end
            end
            OP_GET: begin
                if (rq.key[31]) begin
                    pending_results.push_back(mk(ST_BAD_OPERAND, sh_count, 0, 0, 0, 1));
                end else begin
                    slot = find_slot(k);
                    if (slot >= sh_count || sh_keys[slot] != k)
                        pending_results.push_back(mk(ST_NOT_FOUND, sh_count, 0, 0, 0, 1));
                    else
                        queue_entry(slot);
                end
            end
            OP_RANK: begin
                if (rq.rank >= sh_count)
                    pending_results.push_back(mk(ST_NOT_FOUND, sh_count, 0, 0, 0, 1));
                else
                    queue_entry(rq.rank);
            end
            default: pending_results.push_back(mk(ST_BAD_OPERAND, sh_count, 0, 0, 0, 1));
        endcase
    endtask

    task automatic report(string field, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %0h expected %0h at cycle %0d", field, got, want, cycles);
        errors++;
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_res w;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (pending_results.size() == 0) begin
                report("unexpected result", o_m_tdata[31:0], 0);
            end else begin
                w = pending_results.pop_front();
                if (o_m_tdata[2:0] != w.status)   report("status", o_m_tdata[2:0], w.status);
                if (o_m_tdata[11:3] != w.uniq)    report("unique_keys", o_m_tdata[11:3], w.uniq);
                if (o_m_tdata[42:12] != w.fkey)   report("found_key", o_m_tdata[42:12], w.fkey);
                if (o_m_tdata[73:43] != w.fpos)   report("position", o_m_tdata[73:43], w.fpos);
                if (o_m_tdata[77:74] != w.cnt)    report("count", o_m_tdata[77:74], w.cnt);
                if (o_m_tlast != w.last)          report("tlast", o_m_tlast, w.last);
            end
        end
    end

    // drive one request and hold it until accepted
    task automatic send_request(t_req rq);
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= rq.op;
        i_s_tdata  <= {rq.rank, rq.pos, rq.key};
        do @(posedge i_clk); while (!o_s_tready);
    endtask

    task automatic drain_and_pause();
        i_s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    function automatic t_req rnd_request();
        t_req rq;
        int w;
        w = $urandom_range(99);
        rq.op = (w < 50) ? OP_PUT : (w < 78) ? OP_GET : (w < 95) ? OP_RANK : OP_BAD;
        // narrow key range so lists fill and gets hit
        rq.key = ($urandom_range(9) == 0) ? $urandom() : $urandom_range(23);
        if ($urandom_range(11) == 0) rq.key[31] = 1'b1;
        rq.pos = $urandom();
        if ($urandom_range(11) != 0) rq.pos[31] = 1'b0;
        rq.rank = ($urandom_range(4) == 0) ? 8'($urandom()) : 8'($urandom_range(sh_count + 1));
        return rq;
    endfunction

    function automatic t_row mkrow(t_op op, logic [31:0] k, logic [31:0] p, logic [7:0] rk,
                                   bit typed, t_res res);
        t_row r;
        r.req.op = op; r.req.key = k; r.req.pos = p; r.req.rank = rk;
        r.typed = typed; r.res = res;
        return r;
    endfunction

    initial begin
        t_row table_rows[$];
        t_res none;
        t_req rq;
        int   stall_set [4] = '{0, 0, 53, 7};
        int   idle_set  [4] = '{0, 53, 0, 7};

        none = mk(ST_OK, 0, 0, 0, 0, 1);
        sh_count = 0;
        table_rows.push_back(mkrow(OP_GET,  5, 0, 0, 1, mk(ST_NOT_FOUND, 0, 0, 0, 0, 1)));
        table_rows.push_back(mkrow(OP_RANK, 0, 0, 0, 1, mk(ST_NOT_FOUND, 0, 0, 0, 0, 1)));
        table_rows.push_back(mkrow(OP_PUT, 32'hFFFF_FFFF, 0, 0, 1,
                                   mk(ST_BAD_OPERAND, 0, 0, 0, 0, 1)));
        table_rows.push_back(mkrow(OP_PUT, 0, 32'h8000_0000, 0, 1,
                                   mk(ST_BAD_OPERAND, 0, 0, 0, 0, 1)));
        table_rows.push_back(mkrow(OP_GET, 32'h8000_0000, 0, 0, 1,
                                   mk(ST_BAD_OPERAND, 0, 0, 0, 0, 1)));
        table_rows.push_back(mkrow(OP_BAD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF, 1,
                                   mk(ST_BAD_OPERAND, 0, 0, 0, 0, 1)));
        table_rows.push_back(mkrow(OP_PUT, 0, 0, 0, 1, mk(ST_OK, 1, 0, 0, 1, 1)));
        table_rows.push_back(mkrow(OP_PUT, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 1,
                                   mk(ST_OK, 2, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 1, 1)));
        // middle insertion, then fill that list to its limit
        for (int i = 0; i < N_POS; i++)
            table_rows.push_back(mkrow(OP_PUT, 100, 5 + i, 0, 0, none));
        table_rows.push_back(mkrow(OP_PUT, 100, 13, 0, 1, mk(ST_LIST_FULL, 3, 100, 0, 8, 1)));
        table_rows.push_back(mkrow(OP_GET, 100, 0, 0, 0, none));
        table_rows.push_back(mkrow(OP_RANK, 0, 0, 8'd255, 1, mk(ST_NOT_FOUND, 3, 0, 0, 0, 1)));
        table_rows.push_back(mkrow(OP_RANK, 0, 0, 1, 0, none));
        table_rows.push_back(mkrow(OP_GET, 32'h7FFF_FFFF, 0, 0, 0, none));
        table_rows.push_back(mkrow(OP_GET, 50, 0, 0, 1, mk(ST_NOT_FOUND, 3, 0, 0, 0, 1)));

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (table_rows[i]) begin
            if (table_rows[i].typed) begin
                // keep the shadow in step, but check against the typed result
                predict_lookup(table_rows[i].req);
                void'(pending_results.pop_back());
                pending_results.push_back(table_rows[i].res);
            end else begin
                predict_lookup(table_rows[i].req);
            end
            send_request(table_rows[i].req);
        end

        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct = idle_set[ph];
            recv_stall_pct = stall_set[ph];
            for (int i = 0; i < 36; i++) begin
                rq = rnd_request();
                predict_lookup(rq);
                send_request(rq);
            end
            // sender holds off until everything is back
            drain_and_pause();
        end

        // short tail with light idling on both sides
        send_idle_pct = 7;
        recv_stall_pct = 7;
        for (int i = 0; i < 6; i++) begin
            rq = rnd_request();
            predict_lookup(rq);
            send_request(rq);
        end

        i_s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (64) @(posedge i_clk);
        if (errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule
